[design/bam_pkg.sv]
`default_nettype none

package bam_pkg;

	localparam int ID_W      = 12;
	localparam int WORD_BITS = 64;
	localparam int BIT_AW    = 6;
	// the identifier field reaches 4096 entries at most, so 64 words cover it
	localparam int WORD_AW   = ID_W - BIT_AW;
	localparam int MAP_DEPTH = 1 << WORD_AW;

	localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_FREED     = 2'd2;

	localparam logic ACTION_ALLOC = 1'b0;
	localparam logic ACTION_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MODIFY
	} state_t;

	typedef struct packed {
		logic                 rd_en;
		logic                 wr_en;
		logic [WORD_AW-1:0]   addr;
		logic [WORD_BITS-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic            valid;
		logic [1:0]      status;
		logic [ID_W-1:0] id;
	} result_t;

	// {found, index} of the lowest set bit
	function automatic logic [BIT_AW:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_AW:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, BIT_AW'(i)};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/bam_word_mem.sv]
`default_nettype none

module bam_word_mem (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bam_pkg::mem_req_t             req,
	output logic [bam_pkg::WORD_BITS-1:0]      rdata
);

	logic [bam_pkg::WORD_BITS-1:0] mem [bam_pkg::MAP_DEPTH];
	logic [bam_pkg::MAP_DEPTH-1:0] written_q;
	logic [bam_pkg::WORD_BITS-1:0] rdata_q;
	logic                          rd_written_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				written_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_written_q <= written_q[req.addr];
			end
		end
	end

	// a word never written still holds its reset value: all in use
	assign rdata = rd_written_q ? rdata_q : '1;

endmodule

`default_nettype wire

[design/bam_ctrl.sv]
`default_nettype none

module bam_ctrl #(
	parameter int ID_COUNT = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          action,
	input  wire logic [bam_pkg::ID_W-1:0]      free_id,
	output bam_pkg::mem_req_t                  req,
	input  wire logic [bam_pkg::WORD_BITS-1:0] rdata,
	input  wire logic                          out_free,
	output bam_pkg::result_t                   res
);

	localparam int CMP_W = $clog2(ID_COUNT + 1) > bam_pkg::ID_W ?
		$clog2(ID_COUNT + 1) : bam_pkg::ID_W + 1;
	localparam logic [CMP_W-1:0] ID_LIMIT = CMP_W'(ID_COUNT);

	bam_pkg::state_t state_q, state_d;

	logic                            action_q;
	logic                            skip_q;
	logic [bam_pkg::WORD_AW-1:0]     word_q;
	logic [bam_pkg::BIT_AW-1:0]      bit_q;
	// words that still hold a free identifier
	logic [bam_pkg::MAP_DEPTH-1:0]   avail_q;

	logic                            accept;
	logic [bam_pkg::WORD_AW:0]       first_avail;
	logic [bam_pkg::BIT_AW:0]        first_clear;
	logic [bam_pkg::WORD_BITS-1:0]   set_word;
	logic [bam_pkg::WORD_BITS-1:0]   clr_word;
	logic                            commit;

	assign accept      = in_valid && !in_stall;
	assign first_avail = bam_pkg::lowest_set(avail_q);
	assign first_clear = bam_pkg::lowest_set(~rdata);
	assign set_word    = rdata | (bam_pkg::WORD_BITS'(1) << first_clear[bam_pkg::BIT_AW-1:0]);
	assign clr_word    = rdata & ~(bam_pkg::WORD_BITS'(1) << bit_q);
	assign commit      = (state_q == bam_pkg::ST_MODIFY) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bam_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = bam_pkg::ST_READ;
				end
			end
			bam_pkg::ST_READ: begin
				state_d = bam_pkg::ST_MODIFY;
			end
			bam_pkg::ST_MODIFY: begin
				if (out_free) begin
					state_d = bam_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bam_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		req        = '0;
		req.addr   = word_q;
		res        = '0;
		unique case (state_q)
			bam_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			bam_pkg::ST_READ: begin
				req.rd_en = !skip_q;
			end
			bam_pkg::ST_MODIFY: begin
				res.valid = out_free;
				if (action_q == bam_pkg::ACTION_FREE) begin
					res.status = bam_pkg::STATUS_FREED;
					req.wr_en  = out_free && !skip_q;
					req.wdata  = clr_word;
				end else if (skip_q) begin
					res.status = bam_pkg::STATUS_FULL;
				end else begin
					res.status = bam_pkg::STATUS_ALLOCATED;
					res.id     = {word_q, first_clear[bam_pkg::BIT_AW-1:0]};
					req.wr_en  = out_free;
					req.wdata  = set_word;
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bam_pkg::ST_IDLE;
			avail_q <= '0;
		end else begin
			state_q <= state_d;
			if (commit && !skip_q) begin
				if (action_q == bam_pkg::ACTION_FREE) begin
					avail_q[word_q] <= 1'b1;
				end else begin
					avail_q[word_q] <= (set_word != '1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			if (action == bam_pkg::ACTION_FREE) begin
				// ids past the map are dropped
				skip_q <= !({{(CMP_W - bam_pkg::ID_W){1'b0}}, free_id} < ID_LIMIT);
				word_q <= free_id[bam_pkg::ID_W-1:bam_pkg::BIT_AW];
				bit_q  <= free_id[bam_pkg::BIT_AW-1:0];
			end else begin
				skip_q <= !first_avail[bam_pkg::WORD_AW];
				word_q <= first_avail[bam_pkg::WORD_AW-1:0];
				bit_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[design/bitmap_id_allocator_core.sv]
`default_nettype none

// channel | handshake          | word
// --------+--------------------+--------------------------
// in      | in_valid, in_stall  | action, free_id
// out     | out_valid, out_stall| status, granted_id
//
// One request passes through three steps: accept, word read, modify and write back.
// The lowest free word comes from a 64-bit summary of words with a free bit;
// the word memory's single port sets the pace, one request at a time.
// Reset marks every identifier in use at once through per-word written flags.
// A result waits in the output register while out_stall is high; the next
// request is taken meanwhile and holds in its modify step until the slot frees.

module bitmap_id_allocator_core #(
	parameter int ID_COUNT = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       action,
	input  wire logic [bam_pkg::ID_W-1:0]   free_id,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      status,
	output logic [bam_pkg::ID_W-1:0]        granted_id
);

	bam_pkg::mem_req_t             req;
	bam_pkg::result_t              res;
	logic [bam_pkg::WORD_BITS-1:0] rdata;
	logic                          out_free;
	logic                          out_valid_q;
	logic [1:0]                    status_q;
	logic [bam_pkg::ID_W-1:0]      granted_id_q;

	assign out_free = !out_valid_q || !out_stall;

	bam_word_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	bam_ctrl #(
		.ID_COUNT (ID_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.free_id  (free_id),
		.req      (req),
		.rdata    (rdata),
		.out_free (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q     <= res.status;
			granted_id_q <= res.id;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign granted_id = granted_id_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still in flight");

	a_id_zero_unless_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bam_pkg::STATUS_ALLOCATED |-> granted_id == '0)
		else $error("granted_id nonzero on a non-allocate result");

	a_id_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bam_pkg::STATUS_ALLOCATED |->
			{5'd0, granted_id} < 17'(ID_COUNT))
		else $error("granted identifier beyond the map");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == bam_pkg::STATUS_ALLOCATED || status == bam_pkg::STATUS_FULL ||
			status == bam_pkg::STATUS_FREED)
		else $error("undefined status code");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

typedef struct packed {
	logic [1:0]               status;
	logic [bam_pkg::ID_W-1:0] id;
} grant_t;

// Mirror of the in-use bitmap plus the queue of grants still owed by the block.
class grant_board;
	bit [bam_pkg::WORD_BITS-1:0] in_use [bam_pkg::MAP_DEPTH];
	int     id_count;
	int     map_words;
	int     fails;
	grant_t expected_grants [$];

	function new(int n);
		id_count  = n;
		map_words = (n + bam_pkg::WORD_BITS - 1) / bam_pkg::WORD_BITS;
		fails     = 0;
		foreach (in_use[w]) in_use[w] = '1;
	endfunction

	task report(string what);
		$display("MISMATCH: %s", what);
		fails++;
	endtask

	function void note_request(logic act, logic [bam_pkg::ID_W-1:0] fid);
		grant_t g;
		int     w;
		int     b;
		bit     found;
		g.status = bam_pkg::STATUS_FULL;
		g.id     = '0;
		if (act == bam_pkg::ACTION_FREE) begin
			// out-of-range frees still answer as freed
			if (fid < id_count)
				in_use[fid / bam_pkg::WORD_BITS][fid % bam_pkg::WORD_BITS] = 1'b0;
			g.status = bam_pkg::STATUS_FREED;
		end else begin
			found = 1'b0;
			for (w = 0; w < map_words && !found; w++) begin
				if (in_use[w] != '1) begin
					for (b = 0; b < bam_pkg::WORD_BITS && !found; b++) begin
						if (!in_use[w][b]) begin
							found = 1'b1;
							// spare bits of a short last word are never handed out
							if (w * bam_pkg::WORD_BITS + b < id_count) begin
								in_use[w][b] = 1'b1;
								g.status = bam_pkg::STATUS_ALLOCATED;
								g.id = bam_pkg::ID_W'(w * bam_pkg::WORD_BITS + b);
							end
						end
					end
				end
			end
		end
		expected_grants.push_back(g);
	endfunction

	task check_grant(logic [1:0] st, logic [bam_pkg::ID_W-1:0] id);
		grant_t g;
		if (expected_grants.size() == 0) begin
			report($sformatf("unexpected result word status %0d id %0d", st, id));
		end else begin
			g = expected_grants.pop_front();
			if (st !== g.status)
				report($sformatf("status %0d, wanted %0d", st, g.status));
			if (id !== g.id)
				report($sformatf("granted_id %0d, wanted %0d", id, g.id));
		end
	endtask
endclass

module tb_top;

	localparam int ID_COUNT         = 4096;
	localparam int RANDOM_PER_PHASE = 362;
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int TAIL_CYCLES      = 20;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     action     = bam_pkg::ACTION_ALLOC;
	logic [bam_pkg::ID_W-1:0] free_id    = '0;
	logic                     out_stall  = 1'b0;
	logic                     in_stall;
	logic                     out_valid;
	logic [1:0]               status;
	logic [bam_pkg::ID_W-1:0] granted_id;

	int         idle_pct  = 0;
	int         stall_pct = 0;
	int         quiet     = 0;
	grant_board board;

	bitmap_id_allocator_core #(
		.ID_COUNT(ID_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.free_id(free_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.granted_id(granted_id)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// check before noting, so a word taken at the same edge never meets its own result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_grant(status, granted_id);
			if (in_valid && !in_stall)
				board.note_request(action, free_id);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_word(input logic act, input logic [bam_pkg::ID_W-1:0] fid);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		free_id  <= fid;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_grants;
		in_valid <= 1'b0;
		do @(posedge clk); while (board.expected_grants.size() != 0);
	endtask

	task automatic random_phase(input int alloc_pct, input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < alloc_pct)
				send_word(bam_pkg::ACTION_ALLOC, bam_pkg::ID_W'($urandom_range(0, 4095)));
			else if ($urandom_range(0, 1))
				send_word(bam_pkg::ACTION_FREE, bam_pkg::ID_W'($urandom_range(0, 4095)));
			else
				// low ids: frees of live ids and double frees are common here
				send_word(bam_pkg::ACTION_FREE, bam_pkg::ID_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		board = new(ID_COUNT);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 20;
		stall_pct <= 20;
		send_word(bam_pkg::ACTION_ALLOC, 12'hFFF);  // full straight after reset
		send_word(bam_pkg::ACTION_FREE,  12'h000);
		send_word(bam_pkg::ACTION_FREE,  12'h000);  // already free
		send_word(bam_pkg::ACTION_ALLOC, 12'h000);
		send_word(bam_pkg::ACTION_ALLOC, 12'hFFF);
		send_word(bam_pkg::ACTION_FREE,  12'hFFF);
		send_word(bam_pkg::ACTION_FREE,  12'h03F);
		send_word(bam_pkg::ACTION_FREE,  12'h040);
		send_word(bam_pkg::ACTION_ALLOC, 12'h000);
		send_word(bam_pkg::ACTION_ALLOC, 12'hFFF);
		send_word(bam_pkg::ACTION_ALLOC, 12'hAAA);
		send_word(bam_pkg::ACTION_ALLOC, 12'h555);
		send_word(bam_pkg::ACTION_FREE,  12'hAAA);
		send_word(bam_pkg::ACTION_FREE,  12'h555);
		send_word(bam_pkg::ACTION_ALLOC, 12'h000);
		send_word(bam_pkg::ACTION_ALLOC, 12'hFFF);
		send_word(bam_pkg::ACTION_ALLOC, 12'h000);
		send_word(bam_pkg::ACTION_FREE,  12'hFC0);  // first bit of the last word
		send_word(bam_pkg::ACTION_ALLOC, 12'hFFF);
		send_word(bam_pkg::ACTION_ALLOC, 12'h000);
		drain_grants();

		idle_pct  = 0;
		stall_pct <= 0;
		random_phase(50, RANDOM_PER_PHASE);
		drain_grants();

		idle_pct  = 72;
		stall_pct <= 0;
		random_phase(40, RANDOM_PER_PHASE);
		drain_grants();

		idle_pct  = 0;
		stall_pct <= 72;
		random_phase(60, RANDOM_PER_PHASE);
		drain_grants();

		idle_pct  = 6;
		stall_pct <= 6;
		random_phase(50, RANDOM_PER_PHASE);
		drain_grants();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.expected_grants.size() != 0)
			board.report($sformatf("%0d results never came", board.expected_grants.size()));
		if (board.fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
